FILE: src/stpc_pkg.sv
// Package with the shared types and constants of the staged thermal profile controller.
`timescale 1ns / 1ps
`default_nettype none

package stpc_pkg;

    // Number of stages in a program and the index width that covers them.
    localparam int STAGE_COUNT = 5;
    localparam int STAGE_W     = 3;
    localparam int CFG_IDX_W   = 3;

    localparam int WORD_W = 34;
    localparam int TIME_W = 32;
    localparam int TEMP_W = 8;
    localparam int DUTY_W = 7;
    localparam int SEC_W  = 8;

    // Bit positions inside one stage word.
    localparam int WB_TARGET_LO  = 0;
    localparam int WB_TIMEOUT_LO = 8;
    localparam int WB_RMIN_LO    = 16;
    localparam int WB_RMAX_LO    = 24;
    localparam int WB_FULLPOWER  = 32;
    localparam int WB_VALID      = 33;

    // Register indexes of the configuration port above the stage words.
    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_PERIOD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_STEP      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_DUTY   = 3'd7;

    localparam logic [15:0]       RST_MEASURE_PERIOD = 16'd5000;
    localparam logic [DUTY_W-1:0] RST_DUTY_STEP      = 7'd10;
    localparam logic [DUTY_W-1:0] RST_INITIAL_DUTY   = 7'd50;
    localparam logic [DUTY_W-1:0] DUTY_MAX           = 7'd100;

    // x / 1000 == (x * RECIP_1000) >> RECIP_SHIFT for every 32-bit x.
    localparam logic [28:0] RECIP_1000  = 29'd274877907;
    localparam int          RECIP_SHIFT = 38;

    typedef enum logic [1:0] {
        ACT_CONTINUE = 2'd0,
        ACT_FINISHED = 2'd1,
        ACT_TIMEOUT  = 2'd2
    } t_action;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_START = 1'b1
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [TIME_W-1:0] now_ms;
        logic [TEMP_W-1:0] temperature;
    } t_item;

    typedef struct packed {
        logic [15:0]       measure_period_ms;
        logic [DUTY_W-1:0] duty_step;
        logic [DUTY_W-1:0] initial_duty;
    } t_cfg;

    typedef struct packed {
        logic               running;
        logic [STAGE_W-1:0] stage_number;
        logic [TIME_W-1:0]  stage_start_ms;
        logic [TIME_W-1:0]  last_measure_ms;
        logic [TEMP_W-1:0]  last_temperature;
        logic [DUTY_W-1:0]  duty;
    } t_state;

    typedef struct packed {
        t_action            action;
        logic [DUTY_W-1:0]  duty_percent;
        logic [STAGE_W-1:0] stage_index;
        logic [SEC_W-1:0]   elapsed_seconds;
    } t_result;

endpackage

`default_nettype wire

FILE: src/staged_thermal_profile_controller_unit.sv
// Top level of the staged thermal profile controller: ports, registers and checks.
//
// Usage: the input channel (i_in_valid / o_in_stall) carries one transaction per item:
// an operation (tick with measurement, or start program), the millisecond time and
// the plate temperature. Each input transaction yields exactly one result transaction
// on the output channel (o_out_valid / i_out_stall) with the action, the duty, the
// stage index and the seconds spent in the stage.
// The item is captured in an input register, decided combinationally and placed in the
// result register. One item is taken every cycle while the receiver does not stall.
// If the receiver stalls, the result register holds; the input register then still
// holds its item and o_in_stall rises until the result is taken, so nothing is lost.
// Configuration writes (i_cfg_valid / o_cfg_ready) are always accepted and must only
// be made while the block is idle. Synchronous reset clears both channels, stops any
// program (duty 0, stage 0) and loads the default period, step and initial duty.
`timescale 1ns / 1ps
`default_nettype none

module staged_thermal_profile_controller_unit (
    input  wire                                i_clk,
    input  wire                                i_rst_n,

    input  wire                                i_in_valid,
    output logic                               o_in_stall,
    input  wire                                i_operation,
    input  wire [31:0]                         i_now_ms,
    input  wire [7:0]                          i_temperature,

    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output logic [1:0]                         o_action,
    output logic [6:0]                         o_duty_percent,
    output logic [2:0]                         o_stage_index,
    output logic [7:0]                         o_elapsed_seconds,

    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire [stpc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire [stpc_pkg::WORD_W-1:0]         i_cfg_data
);

    logic [stpc_pkg::WORD_W-1:0] r_stage_word [stpc_pkg::STAGE_COUNT];
    stpc_pkg::t_cfg    r_cfg;
    stpc_pkg::t_state  r_state;
    stpc_pkg::t_state  n_state;
    stpc_pkg::t_item   r_item;
    logic              r_item_valid;
    stpc_pkg::t_result r_out;
    stpc_pkg::t_result n_out;
    logic              r_out_valid;

    logic out_free;
    logic advance;
    logic in_take;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_item_valid && out_free;
    assign o_in_stall = r_item_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < stpc_pkg::STAGE_COUNT; i++) begin
                r_stage_word[i] <= '0;
            end
            r_cfg.measure_period_ms <= stpc_pkg::RST_MEASURE_PERIOD;
            r_cfg.duty_step         <= stpc_pkg::RST_DUTY_STEP;
            r_cfg.initial_duty      <= stpc_pkg::RST_INITIAL_DUTY;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (32'(i_cfg_index) < stpc_pkg::STAGE_COUNT) begin
                r_stage_word[i_cfg_index] <= i_cfg_data;
            end else begin
                case (i_cfg_index)
                    stpc_pkg::CFG_MEASURE_PERIOD: begin
                        r_cfg.measure_period_ms <= i_cfg_data[15:0];
                    end
                    stpc_pkg::CFG_DUTY_STEP: begin
                        r_cfg.duty_step <= i_cfg_data[stpc_pkg::DUTY_W-1:0];
                    end
                    stpc_pkg::CFG_INITIAL_DUTY: begin
                        r_cfg.initial_duty <= i_cfg_data[stpc_pkg::DUTY_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.op          <= stpc_pkg::t_op'(i_operation);
            r_item.now_ms      <= i_now_ms;
            r_item.temperature <= i_temperature;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_state      <= '0;
        end else begin
            if (in_take) begin
                r_item_valid <= 1'b1;
            end else if (advance) begin
                r_item_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    stpc_step u_step (
        .i_item       (r_item),
        .i_cfg        (r_cfg),
        .i_state      (r_state),
        .i_stage_word (r_stage_word),
        .o_state      (n_state),
        .o_result     (n_out)
    );

    assign o_out_valid       = r_out_valid;
    assign o_action          = r_out.action;
    assign o_duty_percent    = r_out.duty_percent;
    assign o_stage_index     = r_out.stage_index;
    assign o_elapsed_seconds = r_out.elapsed_seconds;

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_duty_percent <= stpc_pkg::DUTY_MAX))
        else $error("duty above 100 percent on the output");

    a_stage_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_stage_index) < stpc_pkg::STAGE_COUNT))
        else $error("stage index beyond the stage table");

    a_idle_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.running |-> (r_state.duty == '0))
        else $error("heater duty left on with no program running");

    a_finished_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_action == stpc_pkg::ACT_FINISHED) |-> (o_duty_percent == '0))
        else $error("finished result with the heater still on");

endmodule

`default_nettype wire

FILE: src/stpc_step.sv
// Decision logic for one transaction: next controller state and the result it produces.
`timescale 1ns / 1ps
`default_nettype none

module stpc_step (
    input  wire stpc_pkg::t_item                  i_item,
    input  wire stpc_pkg::t_cfg                   i_cfg,
    input  wire stpc_pkg::t_state                 i_state,
    input  wire [stpc_pkg::WORD_W-1:0]            i_stage_word [stpc_pkg::STAGE_COUNT],
    output stpc_pkg::t_state                      o_state,
    output stpc_pkg::t_result                     o_result
);

    localparam int PROD_W = stpc_pkg::TIME_W + 29;
    localparam int NUM_SLOTS = 1 << stpc_pkg::STAGE_W;

    logic [stpc_pkg::WORD_W-1:0] word_pad [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]        valid_vec;
    logic [NUM_SLOTS-1:0]        full_vec;
    logic [stpc_pkg::WORD_W-1:0] cur_word;

    logic [stpc_pkg::TIME_W-1:0] stage_diff;
    logic [stpc_pkg::TIME_W-1:0] measure_diff;
    logic [PROD_W-1:0]           prod;
    logic [stpc_pkg::SEC_W-1:0]  elapsed;
    logic                        period_due;

    logic [7:0]        target;
    logic [7:0]        timeout;
    logic signed [9:0] rmin_s;
    logic signed [9:0] rmax_s;
    logic signed [9:0] neg_rmin;
    logic signed [9:0] neg_rmax;
    logic signed [9:0] rate_s;
    logic [7:0]        temp;
    logic              rising;
    logic [7:0]        rate;
    logic              end_cond;

    logic [stpc_pkg::STAGE_W-1:0] next_stage;
    logic                         next_ok;
    logic [stpc_pkg::DUTY_W-1:0]  init_clamped;
    logic [7:0]                   duty_sum;
    logic [stpc_pkg::DUTY_W-1:0]  duty_up;
    logic [stpc_pkg::DUTY_W-1:0]  duty_down;
    logic                         stage_restart;

    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (i < stpc_pkg::STAGE_COUNT) begin
                word_pad[i] = i_stage_word[i];
            end else begin
                word_pad[i] = '0;
            end
            valid_vec[i] = word_pad[i][stpc_pkg::WB_VALID];
            full_vec[i]  = word_pad[i][stpc_pkg::WB_FULLPOWER];
        end
    end

    assign cur_word = word_pad[i_state.stage_number];

    // Seconds in stage through a reciprocal multiply; only the low 8 bits are kept.
    assign stage_diff   = i_item.now_ms - i_state.stage_start_ms;
    assign measure_diff = i_item.now_ms - i_state.last_measure_ms;
    assign prod         = PROD_W'(stage_diff) * PROD_W'(stpc_pkg::RECIP_1000);
    assign elapsed      = prod[stpc_pkg::RECIP_SHIFT +: stpc_pkg::SEC_W];
    assign period_due   = measure_diff >= {16'd0, i_cfg.measure_period_ms};

    assign target   = cur_word[stpc_pkg::WB_TARGET_LO +: 8];
    assign timeout  = cur_word[stpc_pkg::WB_TIMEOUT_LO +: 8];
    assign rmin_s   = {{2{cur_word[stpc_pkg::WB_RMIN_LO + 7]}}, cur_word[stpc_pkg::WB_RMIN_LO +: 8]};
    assign rmax_s   = {{2{cur_word[stpc_pkg::WB_RMAX_LO + 7]}}, cur_word[stpc_pkg::WB_RMAX_LO +: 8]};
    assign neg_rmin = -rmin_s;
    assign neg_rmax = -rmax_s;

    assign temp   = i_item.temperature;
    assign rising = temp > i_state.last_temperature;
    assign rate   = rising ? (temp - i_state.last_temperature)
                           : (i_state.last_temperature - temp);
    assign rate_s = {2'b00, rate};

    assign end_cond = (rmax_s > 10'sd0 && temp >= target)
                   || (rmax_s < 10'sd0 && temp <= target)
                   || (rmax_s == 10'sd0 && timeout != 8'd0 && elapsed >= timeout);

    assign next_stage = i_state.stage_number + 1'b1;
    assign next_ok    = (32'(next_stage) < stpc_pkg::STAGE_COUNT) && valid_vec[next_stage];

    assign init_clamped = (i_cfg.initial_duty > stpc_pkg::DUTY_MAX) ? stpc_pkg::DUTY_MAX
                                                                     : i_cfg.initial_duty;
    assign duty_sum  = {1'b0, i_state.duty} + {1'b0, i_cfg.duty_step};
    assign duty_up   = (duty_sum > {1'b0, stpc_pkg::DUTY_MAX}) ? stpc_pkg::DUTY_MAX
                                                                : duty_sum[stpc_pkg::DUTY_W-1:0];
    assign duty_down = (i_cfg.duty_step > i_state.duty) ? '0 : (i_state.duty - i_cfg.duty_step);

    always_comb begin
        o_state         = i_state;
        o_result.action = stpc_pkg::ACT_CONTINUE;
        stage_restart   = 1'b0;

        if (i_item.op == stpc_pkg::OP_START) begin
            o_state.running          = 1'b1;
            o_state.stage_number     = '0;
            o_state.last_measure_ms  = i_item.now_ms;
            o_state.stage_start_ms   = i_item.now_ms;
            o_state.last_temperature = temp;
            o_state.duty             = init_clamped;
            stage_restart            = 1'b1;
        end else if (!i_state.running) begin
            o_result.action = stpc_pkg::ACT_FINISHED;
        end else if (period_due) begin
            o_state.last_measure_ms  = i_item.now_ms;
            o_state.last_temperature = temp;
            if (end_cond) begin
                if (!next_ok) begin
                    o_state.duty    = '0;
                    o_state.running = 1'b0;
                    o_result.action = stpc_pkg::ACT_FINISHED;
                end else begin
                    o_state.stage_number   = next_stage;
                    o_state.stage_start_ms = i_item.now_ms;
                    o_state.duty           = full_vec[next_stage] ? stpc_pkg::DUTY_MAX
                                                                  : init_clamped;
                    stage_restart          = 1'b1;
                end
            end else if (rmax_s == 10'sd0) begin
                // Hold stage: steer the duty towards the target temperature.
                if (target > temp) begin
                    o_state.duty = duty_up;
                end else if (target < temp) begin
                    o_state.duty = duty_down;
                end
            end else if (elapsed > timeout) begin
                o_result.action = stpc_pkg::ACT_TIMEOUT;
            end else if (rising) begin
                if (rmax_s < 10'sd0) begin
                    o_state.duty = '0;
                end else if (rate_s < rmin_s) begin
                    o_state.duty = duty_up;
                end else if (rate_s > rmax_s) begin
                    o_state.duty = duty_down;
                end
            end else begin
                if (rmax_s > 10'sd0) begin
                    o_state.duty = stpc_pkg::DUTY_MAX;
                end else if (rate_s < neg_rmin) begin
                    o_state.duty = duty_down;
                end else if (rate_s > neg_rmax) begin
                    o_state.duty = duty_up;
                end
            end
        end

        o_result.duty_percent    = o_state.duty;
        o_result.stage_index     = o_state.stage_number;
        // A fresh stage start makes the elapsed time zero.
        o_result.elapsed_seconds = stage_restart ? '0 : elapsed;
    end

endmodule

`default_nettype wire

FILE: test/stpc_heater_checker.sv
// Checker for the staged thermal profile controller: predicts each result and compares it.
`timescale 1ns / 1ps

module stpc_heater_checker (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    input  wire                            i_in_stall,
    input  wire                            i_operation,
    input  wire [31:0]                     i_now_ms,
    input  wire [7:0]                      i_temperature,
    input  wire                            i_out_valid,
    input  wire                            i_out_stall,
    input  wire [1:0]                      i_action,
    input  wire [6:0]                      i_duty_percent,
    input  wire [2:0]                      i_stage_index,
    input  wire [7:0]                      i_elapsed_seconds,
    input  wire                            i_cfg_valid,
    input  wire                            i_cfg_ready,
    input  wire [stpc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [stpc_pkg::WORD_W-1:0]     i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    import stpc_pkg::*;

    // Programmed table and settings as the block should hold them.
    logic [WORD_W-1:0]  stage_words [STAGE_COUNT];
    logic [15:0]        period_ms;
    logic [DUTY_W-1:0]  step_pct;
    logic [DUTY_W-1:0]  entry_duty;

    // Program state of the heater.
    logic               running;
    logic [STAGE_W-1:0] stage_no;
    logic [TIME_W-1:0]  stage_start_ms;
    logic [TIME_W-1:0]  last_measure_ms;
    logic [TEMP_W-1:0]  last_temp;
    int                 duty;

    t_result            expected_outcomes [$];
    int                 fail_total = 0;

    function automatic int clamp_percent(int v);
        if (v > int'(DUTY_MAX)) return int'(DUTY_MAX);
        if (v < 0) return 0;
        return v;
    endfunction

    // Applies one item to the heater state and returns the result it should give.
    function automatic t_result advance_heater(t_op op, logic [TIME_W-1:0] now,
                                               logic [TEMP_W-1:0] temp);
        t_result            outcome;
        logic [WORD_W-1:0]  word;
        logic [WORD_W-1:0]  next_word;
        logic [TIME_W-1:0]  since_measure;
        logic [TIME_W-1:0]  secs;
        int                 target;
        int                 timeout;
        int                 rmin;
        int                 rmax;
        int                 elapsed;
        int                 rate;
        int                 t;
        int                 next;
        logic               rising;

        outcome.action = ACT_CONTINUE;
        since_measure  = now - last_measure_ms;
        if (op == OP_START) begin
            running         = 1'b1;
            stage_no        = '0;
            last_measure_ms = now;
            stage_start_ms  = now;
            last_temp       = temp;
            duty            = clamp_percent(int'(entry_duty));
        end else if (!running) begin
            outcome.action = ACT_FINISHED;
        end else if (since_measure >= {16'd0, period_ms}) begin
            word    = (int'(stage_no) < STAGE_COUNT) ? stage_words[stage_no] : '0;
            target  = int'(word[7:0]);
            timeout = int'(word[15:8]);
            rmin    = int'($signed(word[23:16]));
            rmax    = int'($signed(word[31:24]));
            secs    = (now - stage_start_ms) / 32'd1000;
            elapsed = int'(secs[7:0]);
            t       = int'(temp);
            rising  = temp > last_temp;
            rate    = rising ? t - int'(last_temp) : int'(last_temp) - t;

            last_measure_ms = now;
            last_temp       = temp;

            if ((rmax > 0 && t >= target) || (rmax < 0 && t <= target) ||
                (rmax == 0 && timeout != 0 && elapsed >= timeout)) begin
                next      = int'(stage_no) + 1;
                next_word = (next < STAGE_COUNT) ? stage_words[next] : '0;
                if (next >= STAGE_COUNT || !next_word[WB_VALID]) begin
                    duty           = 0;
                    running        = 1'b0;
                    outcome.action = ACT_FINISHED;
                end else begin
                    stage_no       = next[STAGE_W-1:0];
                    stage_start_ms = now;
                    duty = next_word[WB_FULLPOWER] ? int'(DUTY_MAX)
                                                   : clamp_percent(int'(entry_duty));
                end
            end else if (rmax == 0) begin
                if (target > t) duty = clamp_percent(duty + int'(step_pct));
                else if (target < t) duty = clamp_percent(duty - int'(step_pct));
            end else if (elapsed > timeout) begin
                outcome.action = ACT_TIMEOUT;
            end else if (rising) begin
                if (rmax < 0) duty = 0;
                else if (rate < rmin) duty = clamp_percent(duty + int'(step_pct));
                else if (rate > rmax) duty = clamp_percent(duty - int'(step_pct));
            end else begin
                // A heating stage that is losing heat goes straight to full power.
                if (rmax > 0) duty = int'(DUTY_MAX);
                else if (rate < -rmin) duty = clamp_percent(duty - int'(step_pct));
                else if (rate > -rmax) duty = clamp_percent(duty + int'(step_pct));
            end
        end

        secs                    = (now - stage_start_ms) / 32'd1000;
        outcome.duty_percent    = duty[DUTY_W-1:0];
        outcome.stage_index     = stage_no;
        outcome.elapsed_seconds = secs[SEC_W-1:0];
        return outcome;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            for (int s = 0; s < STAGE_COUNT; s++) stage_words[s] = '0;
            period_ms       = RST_MEASURE_PERIOD;
            step_pct        = RST_DUTY_STEP;
            entry_duty      = RST_INITIAL_DUTY;
            running         = 1'b0;
            stage_no        = '0;
            stage_start_ms  = '0;
            last_measure_ms = '0;
            last_temp       = '0;
            duty            = 0;
            expected_outcomes.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MEASURE_PERIOD: period_ms  = i_cfg_data[15:0];
                    CFG_DUTY_STEP:      step_pct   = i_cfg_data[DUTY_W-1:0];
                    CFG_INITIAL_DUTY:   entry_duty = i_cfg_data[DUTY_W-1:0];
                    default:            stage_words[i_cfg_index] = i_cfg_data;
                endcase
            end

            // Results leave before new items are predicted, so a result can never
            // be matched against the expectation of its own clock edge.
            if (i_out_valid && !i_out_stall) begin
                if (expected_outcomes.size() == 0) begin
                    if (fail_total < 10)
                        $display("%0t: result with nothing expected: act %0d duty %0d",
                                 $realtime, i_action, i_duty_percent);
                    fail_total++;
                end else begin
                    want = expected_outcomes.pop_front();
                    if (i_action !== want.action || i_duty_percent !== want.duty_percent ||
                        i_stage_index !== want.stage_index ||
                        i_elapsed_seconds !== want.elapsed_seconds) begin
                        if (fail_total < 10)
                            $display("%0t: expected act %0d duty %0d stage %0d secs %0d, got %0d %0d %0d %0d",
                                     $realtime, want.action, want.duty_percent,
                                     want.stage_index, want.elapsed_seconds, i_action,
                                     i_duty_percent, i_stage_index, i_elapsed_seconds);
                        fail_total++;
                    end
                end
            end

            if (i_in_valid && !i_in_stall)
                expected_outcomes.push_back(
                    advance_heater(t_op'(i_operation), i_now_ms, i_temperature));
        end
        o_pending    = expected_outcomes.size();
        o_fail_count = fail_total;
    end

endmodule

FILE: test/staged_thermal_profile_controller_unit_tb.sv
// Testbench top of the staged thermal profile controller: clock, reset, stimulus, verdict.
`timescale 1ns / 1ps

module staged_thermal_profile_controller_unit_tb;
    import stpc_pkg::*;

    localparam int REG_COUNT   = 8;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 182;
    localparam int HOLD_CYCLES = 80;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_in_valid    = 1'b0;
    logic                 i_operation   = 1'b0;
    logic [31:0]          i_now_ms      = '0;
    logic [7:0]           i_temperature = '0;
    logic                 i_out_stall   = 1'b0;
    logic                 i_cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [WORD_W-1:0]    i_cfg_data    = '0;

    wire                  o_in_stall;
    wire                  o_out_valid;
    wire [1:0]            o_action;
    wire [6:0]            o_duty_percent;
    wire [2:0]            o_stage_index;
    wire [7:0]            o_elapsed_seconds;
    wire                  o_cfg_ready;

    int                   fail_count;
    int                   pending;

    logic [31:0]          clock_ms     = 32'hFFFF_F000;
    int                   plate        = 20;
    logic [WORD_W-1:0]    regs [REG_COUNT];
    bit                   no_idle      = 1'b0;
    bit                   hold_request = 1'b0;
    bit                   saw_finish   = 1'b0;

    always #5 i_clk = ~i_clk;

    staged_thermal_profile_controller_unit i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_operation       (i_operation),
        .i_now_ms          (i_now_ms),
        .i_temperature     (i_temperature),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_action          (o_action),
        .o_duty_percent    (o_duty_percent),
        .o_stage_index     (o_stage_index),
        .o_elapsed_seconds (o_elapsed_seconds),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    stpc_heater_checker u_heater_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_operation       (i_operation),
        .i_now_ms          (i_now_ms),
        .i_temperature     (i_temperature),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_action          (o_action),
        .i_duty_percent    (o_duty_percent),
        .i_stage_index     (o_stage_index),
        .i_elapsed_seconds (o_elapsed_seconds),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    // Result side: random stalls, or a long counted hold-off when one is requested.
    initial begin : out_stall_drive
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= !no_idle && ($urandom_range(99) < 12);
            end
        end
    end

    // Lets the stimulus restart a program soon after one has finished.
    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall && o_action == ACT_FINISHED) saw_finish = 1'b1;
    end

    function automatic logic [WORD_W-1:0] pack_stage(bit valid, bit fullpower, int rmax,
                                                     int rmin, int timeout, int target);
        return {valid, fullpower, rmax[7:0], rmin[7:0], timeout[7:0], target[7:0]};
    endfunction

    function automatic logic [31:0] measure_gap();
        int unsigned span;
        int unsigned roll;
        span = 32'(regs[CFG_MEASURE_PERIOD][15:0]);
        roll = $urandom_range(99);
        if (roll < 60) return span + $urandom_range(span / 4 + 10);
        if (roll < 75) return $urandom_range(span);
        if (roll < 95) return $urandom_range(3 * span + 1000);
        return $urandom();
    endfunction

    function automatic void shuffle_program(int p);
        int kind;
        int rmax;
        int rmin;
        int timeout;
        for (int s = 0; s < STAGE_COUNT; s++) begin
            kind = $urandom_range(9);
            if (kind <= 3) begin
                rmax = 1 + int'($urandom_range(19));
                rmin = int'($urandom_range(15)) - 5;
            end else if (kind <= 6) begin
                rmax = -1 - int'($urandom_range(19));
                rmin = -1 - int'($urandom_range(29));
            end else begin
                rmax = 0;
                rmin = int'($urandom_range(255));
            end
            kind = $urandom_range(9);
            timeout = (kind == 0) ? 0 : (kind == 1) ? 255 : int'($urandom_range(40, 1));
            regs[s] = pack_stage($urandom_range(9) != 0, 1'($urandom_range(1)), rmax, rmin,
                                 timeout, int'($urandom_range(255)));
            // Now and then a stage word with every bit left to chance.
            if ($urandom_range(9) == 0) regs[s] = {2'($urandom_range(3)), $urandom()};
        end
        regs[CFG_MEASURE_PERIOD] = WORD_W'((p == 1) ? 65535 : (p == 2) ? 1
                                           : $urandom_range(6000, 200));
        regs[CFG_DUTY_STEP]      = WORD_W'((p == 0) ? 0 : (p == 1) ? 100 : (p == 4) ? 127
                                           : $urandom_range(30, 1));
        regs[CFG_INITIAL_DUTY]   = WORD_W'((p == 2) ? 0 : (p == 3) ? 100
                                           : $urandom_range(127));
    endfunction

    // Offers one item and returns once the block has taken the transaction.
    task automatic offer_item(t_op op, logic [31:0] now, logic [7:0] temp);
        while (!no_idle && $urandom_range(99) < 12) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_operation   <= op;
        i_now_ms      <= now;
        i_temperature <= temp;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic tick_after(logic [31:0] gap, int temp);
        clock_ms += gap;
        offer_item(OP_TICK, clock_ms, temp[7:0]);
    endtask

    // Waits until every result is back and the block has gone quiet.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_registers();
        for (int r = 0; r < REG_COUNT; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= r[CFG_IDX_W-1:0];
            i_cfg_data  <= regs[r];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int roll;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A tick with no program running, under the reset settings.
        offer_item(OP_TICK, 32'hFFFF_FFFF, 8'd0);

        // Heat, hold, cool, then a stage that times out and ends the program.
        regs[0] = pack_stage(1'b1, 1'b0, 6, 2, 100, 100);
        regs[1] = pack_stage(1'b1, 1'b0, 0, 0, 3, 100);
        regs[2] = pack_stage(1'b1, 1'b1, -2, -8, 255, 40);
        regs[3] = pack_stage(1'b1, 1'b0, 127, 0, 0, 255);
        regs[4] = pack_stage(1'b0, 1'b0, 0, 0, 0, 0);
        regs[CFG_MEASURE_PERIOD] = 1000;
        regs[CFG_DUTY_STEP]      = 10;
        regs[CFG_INITIAL_DUTY]   = 50;
        settle();
        load_registers();
        offer_item(OP_START, clock_ms, 8'd20);
        tick_after(500, 22);
        tick_after(600, 21);
        tick_after(1000, 22);
        tick_after(1000, 40);
        tick_after(1000, 44);
        tick_after(1000, 100);
        tick_after(1000, 90);
        tick_after(1000, 110);
        tick_after(1000, 100);
        tick_after(1000, 105);
        tick_after(1000, 104);
        tick_after(1000, 90);
        tick_after(1000, 40);
        tick_after(2500, 41);
        tick_after(1000, 255);
        tick_after(5, 0);

        // Zero period, oversized step and initial duty, and stage 0 marked invalid.
        regs[0] = pack_stage(1'b0, 1'b0, 0, -128, 0, 128);
        regs[1] = pack_stage(1'b1, 1'b1, -128, 127, 255, 0);
        regs[CFG_MEASURE_PERIOD] = 0;
        regs[CFG_DUTY_STEP]      = 127;
        regs[CFG_INITIAL_DUTY]   = 127;
        settle();
        load_registers();
        offer_item(OP_START, clock_ms, 8'd255);
        tick_after(0, 0);
        tick_after(0, 255);
        tick_after(0, 128);

        for (int p = 0; p < PHASES; p++) begin
            settle();
            shuffle_program(p);
            load_registers();
            no_idle    = (p == 5);
            saw_finish = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ((p == 3 || p == 6) && n == 60) hold_request = 1'b1;
                roll = $urandom_range(99);
                if ((saw_finish && roll < 70) || roll < 3) begin
                    saw_finish = 1'b0;
                    plate      = $urandom_range(255);
                    offer_item(OP_START, clock_ms, plate[7:0]);
                end else if (roll < 10) begin
                    offer_item(t_op'($urandom_range(1)), $urandom(), 8'($urandom_range(255)));
                end else begin
                    // The plate mostly drifts, and sometimes lands near a stage target.
                    if ($urandom_range(99) < 15)
                        plate = int'(regs[$urandom_range(STAGE_COUNT - 1)][7:0])
                              + int'($urandom_range(4)) - 2;
                    else
                        plate += int'($urandom_range(14)) - 6;
                    if (plate < 0) plate = 0;
                    if (plate > 255) plate = 255;
                    tick_after(measure_gap(), plate);
                end
            end
        end

        settle();
        repeat (6) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin : run_limit
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
